FILE: design/imuks_pkg.sv
`default_nettype none
// Shared constants, codes and control types for the six-axis IMU Kalman smoother.
package imuks_pkg;

    // Filter geometry and number formats
    localparam int CHANNELS  = 6;
    localparam int AXES      = 6;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NOISE_W   = 24;

    // Gain is unsigned with one integer bit so that 1.0 is exact.
    localparam int K_W       = FRAC_BITS + 1;
    // Predicted covariance plus noise needs one bit more than a sample.
    localparam int SUM_W     = DATA_W + 1;
    // Signed second multiplier operand: sample differences and magnitudes.
    localparam int OPB_W     = DATA_W + 1;
    localparam int PROD_W    = K_W + 1 + OPB_W;
    // Estimate plus correction before saturation.
    localparam int UPD_W     = DATA_W + 3;
    // One quotient bit per division step.
    localparam int DIV_STEPS = K_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [K_W-1:0]     ONE_K     = K_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0]  COV_RESET = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [NOISE_W-1:0] Q_RESET   =
        NOISE_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [NOISE_W-1:0] R_RESET   =
        NOISE_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);

    // Configuration register indexes
    localparam int REG_IDX_W = 1;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROCESS_NOISE = 1'b0,
        REG_MEASURE_NOISE = 1'b1
    } reg_idx_t;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_CHANNEL = 3'd0,
        MUL_OMK_SQ  = 3'd1,
        MUL_A_PPRED = 3'd2,
        MUL_K_SQ    = 3'd3,
        MUL_C_R     = 3'd4
    } mul_sel_t;

    // Destination of the shifted product register
    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_A    = 3'd1,
        CAP_B    = 3'd2,
        CAP_C    = 3'd3,
        CAP_COV  = 3'd4
    } cap_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load_z;
        logic     load_first;
        logic     pred;
        logic     div_init;
        logic     div_step;
        logic     gain;
        logic     mul_en;
        mul_sel_t mul_sel;
        cap_sel_t cap_sel;
        logic     est_update;
        logic     out_load;
    } imuks_cmd_t;

endpackage
`default_nettype wire

FILE: design/imuks_datapath.sv
`default_nettype none
// Datapath: noise registers, gain divider, shared multiplier, estimates and covariance.
module imuks_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire imuks_pkg::imuks_cmd_t                cmd,
    input  wire logic                                 cfg_we,
    input  wire logic [imuks_pkg::REG_IDX_W-1:0]      cfg_addr,
    input  wire logic [imuks_pkg::NOISE_W-1:0]        cfg_wdata,
    input  wire logic [imuks_pkg::DATA_W-1:0]         z_in    [imuks_pkg::CHANNELS],
    output logic      [imuks_pkg::DATA_W-1:0]         est_out [imuks_pkg::CHANNELS]
);

    // Architectural state
    logic [imuks_pkg::NOISE_W-1:0] q_reg, q_next;
    logic [imuks_pkg::NOISE_W-1:0] r_reg, r_next;
    logic [imuks_pkg::DATA_W-1:0]  cov_reg, cov_next;
    logic [imuks_pkg::DATA_W-1:0]  est_reg [imuks_pkg::CHANNELS];
    logic [imuks_pkg::DATA_W-1:0]  est_next [imuks_pkg::CHANNELS];

    // Working registers
    logic [imuks_pkg::DATA_W-1:0]  z_reg [imuks_pkg::CHANNELS];
    logic [imuks_pkg::DATA_W-1:0]  z_next [imuks_pkg::CHANNELS];
    logic [imuks_pkg::DATA_W-1:0]  out_reg [imuks_pkg::CHANNELS];
    logic [imuks_pkg::DATA_W-1:0]  out_next [imuks_pkg::CHANNELS];
    logic [imuks_pkg::DATA_W-1:0]  ppred_reg, ppred_next;
    logic [imuks_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [imuks_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [imuks_pkg::K_W-1:0]     dvd_reg, dvd_next;
    logic [imuks_pkg::K_W-1:0]     quo_reg, quo_next;
    logic [imuks_pkg::K_W-1:0]     k_reg, k_next;
    logic [imuks_pkg::K_W-1:0]     omk_reg, omk_next;
    logic [imuks_pkg::K_W-1:0]     a_reg, a_next;
    logic [imuks_pkg::SUM_W-1:0]   b_reg, b_next;
    logic [imuks_pkg::K_W-1:0]     c_reg, c_next;
    logic signed [imuks_pkg::PROD_W-1:0] prod_reg, prod_next;

    // Intermediate values
    logic [imuks_pkg::SUM_W-1:0]   ppred_sum;
    logic [imuks_pkg::DATA_W-1:0]  ppred_sat;
    logic [imuks_pkg::SUM_W:0]     rem_sh;
    logic [imuks_pkg::SUM_W:0]     rem_sub;
    logic                          rem_geq;
    logic [imuks_pkg::K_W-1:0]     k_calc;
    logic [imuks_pkg::K_W-1:0]     opa;
    logic signed [imuks_pkg::OPB_W-1:0]  opb;
    logic signed [imuks_pkg::OPB_W-1:0]  chan_diff;
    logic signed [imuks_pkg::PROD_W-1:0] prod_calc;
    logic signed [imuks_pkg::PROD_W-1:0] prod_sh;
    logic signed [imuks_pkg::UPD_W-1:0]  upd_sum;
    logic [imuks_pkg::UPD_W-imuks_pkg::DATA_W:0] upd_top;
    logic [imuks_pkg::DATA_W-1:0]  est_new;
    logic [imuks_pkg::SUM_W:0]     cov_sum;

    // Predicted covariance, saturated to the unsigned range
    assign ppred_sum = {1'b0, cov_reg} + imuks_pkg::SUM_W'(q_reg);
    assign ppred_sat = ppred_sum[imuks_pkg::DATA_W] ? '1 : ppred_sum[imuks_pkg::DATA_W-1:0];

    // One restoring division step: bring in the next dividend bit and try a subtract.
    assign rem_sh  = {rem_reg, dvd_reg[imuks_pkg::K_W-1]};
    assign rem_sub = rem_sh - {1'b0, sum_reg};
    assign rem_geq = (rem_sh >= {1'b0, sum_reg});

    // Gain is zero for a zero denominator and never above one.
    always_comb
    begin
        if (sum_reg == '0)
        begin
            k_calc = '0;
        end
        else if (quo_reg > imuks_pkg::ONE_K)
        begin
            k_calc = imuks_pkg::ONE_K;
        end
        else
        begin
            k_calc = quo_reg;
        end
    end

    // Operand selection for the shared multiplier
    assign chan_diff = $signed({z_reg[0][imuks_pkg::DATA_W-1], z_reg[0]})
                     - $signed({est_reg[0][imuks_pkg::DATA_W-1], est_reg[0]});

    always_comb
    begin
        case (cmd.mul_sel)
            imuks_pkg::MUL_CHANNEL:
            begin
                opa = k_reg;
                opb = chan_diff;
            end
            imuks_pkg::MUL_OMK_SQ:
            begin
                opa = omk_reg;
                opb = $signed(imuks_pkg::OPB_W'(omk_reg));
            end
            imuks_pkg::MUL_A_PPRED:
            begin
                opa = a_reg;
                opb = $signed(imuks_pkg::OPB_W'(ppred_reg));
            end
            imuks_pkg::MUL_K_SQ:
            begin
                opa = k_reg;
                opb = $signed(imuks_pkg::OPB_W'(k_reg));
            end
            imuks_pkg::MUL_C_R:
            begin
                opa = c_reg;
                opb = $signed(imuks_pkg::OPB_W'(r_reg));
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_calc = $signed({1'b0, opa}) * opb;
    assign prod_sh   = prod_reg >>> imuks_pkg::FRAC_BITS;

    // Estimate correction with signed saturation
    assign upd_sum = $signed({{3{est_reg[0][imuks_pkg::DATA_W-1]}}, est_reg[0]})
                   + $signed(prod_sh[imuks_pkg::UPD_W-1:0]);
    assign upd_top = upd_sum[imuks_pkg::UPD_W-1:imuks_pkg::DATA_W-1];

    always_comb
    begin
        if ((&upd_top) || !(|upd_top))
        begin
            est_new = upd_sum[imuks_pkg::DATA_W-1:0];
        end
        else if (upd_sum[imuks_pkg::UPD_W-1])
        begin
            est_new = {1'b1, {(imuks_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            est_new = {1'b0, {(imuks_pkg::DATA_W-1){1'b1}}};
        end
    end

    // Joseph-form covariance: b from the product register, d is the fresh product.
    assign cov_sum = {1'b0, b_reg}
                   + (imuks_pkg::SUM_W+1)'(prod_sh[imuks_pkg::NOISE_W:0]);

    // Configuration writes
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                imuks_pkg::REG_PROCESS_NOISE: q_next = cfg_wdata;
                imuks_pkg::REG_MEASURE_NOISE: r_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sample, estimate and output arrays; the channel loop rotates through slot zero.
    always_comb
    begin
        for (int i = 0; i < imuks_pkg::CHANNELS; i++)
        begin
            z_next[i]   = z_reg[i];
            est_next[i] = est_reg[i];
            out_next[i] = out_reg[i];
        end
        if (cmd.load_z)
        begin
            for (int i = 0; i < imuks_pkg::CHANNELS; i++)
            begin
                z_next[i] = z_in[i];
            end
        end
        if (cmd.load_first)
        begin
            for (int i = 0; i < imuks_pkg::CHANNELS; i++)
            begin
                est_next[i] = z_in[i];
            end
        end
        if (cmd.est_update)
        begin
            for (int i = 0; i < imuks_pkg::CHANNELS - 1; i++)
            begin
                z_next[i]   = z_reg[i+1];
                est_next[i] = est_reg[i+1];
            end
            z_next[imuks_pkg::CHANNELS-1]   = z_reg[0];
            est_next[imuks_pkg::CHANNELS-1] = est_new;
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < imuks_pkg::CHANNELS; i++)
            begin
                out_next[i] = est_reg[i];
            end
        end
    end

    // Prediction, division and gain
    always_comb
    begin
        ppred_next = ppred_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        k_next     = k_reg;
        omk_next   = omk_reg;
        if (cmd.pred)
        begin
            ppred_next = ppred_sat;
        end
        if (cmd.div_init)
        begin
            // The quotient fits K_W bits, so the top dividend bits seed the remainder.
            sum_next = {1'b0, ppred_reg} + imuks_pkg::SUM_W'(r_reg);
            rem_next = imuks_pkg::SUM_W'(ppred_reg >> 1);
            dvd_next = {ppred_reg[0], {imuks_pkg::FRAC_BITS{1'b0}}};
            quo_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next = rem_geq ? rem_sub[imuks_pkg::SUM_W-1:0] : rem_sh[imuks_pkg::SUM_W-1:0];
            dvd_next = {dvd_reg[imuks_pkg::K_W-2:0], 1'b0};
            quo_next = {quo_reg[imuks_pkg::K_W-2:0], rem_geq};
        end
        if (cmd.gain)
        begin
            k_next   = k_calc;
            omk_next = imuks_pkg::ONE_K - k_calc;
        end
    end

    // Multiplier output and covariance terms
    always_comb
    begin
        prod_next = prod_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        cov_next  = cov_reg;
        if (cmd.mul_en)
        begin
            prod_next = prod_calc;
        end
        case (cmd.cap_sel)
            imuks_pkg::CAP_A:   a_next = prod_sh[imuks_pkg::K_W-1:0];
            imuks_pkg::CAP_B:   b_next = prod_sh[imuks_pkg::SUM_W-1:0];
            imuks_pkg::CAP_C:   c_next = prod_sh[imuks_pkg::K_W-1:0];
            imuks_pkg::CAP_COV:
            begin
                if (|cov_sum[imuks_pkg::SUM_W:imuks_pkg::DATA_W])
                begin
                    cov_next = '1;
                end
                else
                begin
                    cov_next = cov_sum[imuks_pkg::DATA_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // State registers with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= imuks_pkg::Q_RESET;
            r_reg   <= imuks_pkg::R_RESET;
            cov_reg <= imuks_pkg::COV_RESET;
            for (int i = 0; i < imuks_pkg::CHANNELS; i++)
            begin
                est_reg[i] <= '0;
            end
        end
        else
        begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            cov_reg <= cov_next;
            for (int i = 0; i < imuks_pkg::CHANNELS; i++)
            begin
                est_reg[i] <= est_next[i];
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < imuks_pkg::CHANNELS; i++)
        begin
            z_reg[i]   <= z_next[i];
            out_reg[i] <= out_next[i];
        end
        ppred_reg <= ppred_next;
        sum_reg   <= sum_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        k_reg     <= k_next;
        omk_reg   <= omk_next;
        prod_reg  <= prod_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
    end

    assign est_out = out_reg;

endmodule
`default_nettype wire

FILE: design/imuks_ctrl.sv
`default_nettype none
// Controller: request handshakes, started flag and the sequence of datapath commands.
module imuks_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output imuks_pkg::imuks_cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PRED  = 13'b0000000000010,
        S_DINIT = 13'b0000000000100,
        S_DIV   = 13'b0000000001000,
        S_GAIN  = 13'b0000000010000,
        S_CMUL  = 13'b0000000100000,
        S_CUPD  = 13'b0000001000000,
        S_MA    = 13'b0000010000000,
        S_CA    = 13'b0000100000000,
        S_CC    = 13'b0001000000000,
        S_CB    = 13'b0010000000000,
        S_CD    = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [imuks_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                        started_reg, started_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        in_accept;
    logic                        out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    // The output register may be reloaded when empty or being emptied this cycle.
    assign out_free  = !out_valid_reg || out_ready;

    // Next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        cmd          = '0;
        cmd.mul_sel  = imuks_pkg::MUL_CHANNEL;
        cmd.cap_sel  = imuks_pkg::CAP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.load_z     = 1'b1;
                    cmd.load_first = !started_reg;
                    started_next   = 1'b1;
                    state_next     = started_reg ? S_PRED : S_DONE;
                end
            end
            S_PRED:
            begin
                cmd.pred   = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == imuks_pkg::CNT_W'(imuks_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.gain   = 1'b1;
                cnt_next   = '0;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = imuks_pkg::MUL_CHANNEL;
                state_next  = S_CUPD;
            end
            S_CUPD:
            begin
                cmd.est_update = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == imuks_pkg::CNT_W'(imuks_pkg::CHANNELS - 1))
                begin
                    state_next = S_MA;
                end
                else
                begin
                    state_next = S_CMUL;
                end
            end
            // Covariance terms: captures overlap with the next multiply.
            S_MA:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = imuks_pkg::MUL_OMK_SQ;
                state_next  = S_CA;
            end
            S_CA:
            begin
                cmd.cap_sel = imuks_pkg::CAP_A;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = imuks_pkg::MUL_K_SQ;
                state_next  = S_CC;
            end
            S_CC:
            begin
                cmd.cap_sel = imuks_pkg::CAP_C;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = imuks_pkg::MUL_A_PPRED;
                state_next  = S_CB;
            end
            S_CB:
            begin
                cmd.cap_sel = imuks_pkg::CAP_B;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = imuks_pkg::MUL_C_R;
                state_next  = S_CD;
            end
            S_CD:
            begin
                cmd.cap_sel = imuks_pkg::CAP_COV;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output request flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // The first request after reset skips filtering and goes straight to output.
    a_first_skips : assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !started_reg) |=> (state_reg == S_DONE))
        else $error("first request did not bypass the filter");

    // Later requests always run the full predict and update.
    a_later_filters : assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && started_reg) |=> (state_reg == S_PRED))
        else $error("filtered request did not start with prediction");

    // The divider runs exactly one step per quotient bit.
    a_div_length : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == imuks_pkg::CNT_W'(imuks_pkg::DIV_STEPS - 1))
        |=> (state_reg == S_GAIN))
        else $error("divider step count mismatch");

    // A finished result waits while the output register is still occupied.
    a_done_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result overwrote an unaccepted output");

    // The started flag never drops outside reset.
    a_started_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag cleared");
`endif

endmodule
`default_nettype wire

FILE: design/imu_six_axis_kalman_smoother.sv
`default_nettype none
// Top level of the six-axis IMU Kalman smoother: six scalar filters sharing one covariance.
// The first request after reset goes straight to the output register; later ones run prediction,
// the 17-step serial gain divider, a multiply plus an update per axis and the covariance terms.
// A new request is taken in the cycle after the output register loads; one request at a time.
// Reset (async, active low) clears estimates, sets covariance to one and noise to defaults.
module imu_six_axis_kalman_smoother (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [imuks_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  wire logic [imuks_pkg::NOISE_W-1:0]       cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [imuks_pkg::DATA_W-1:0] accel_x,
    input  wire logic signed [imuks_pkg::DATA_W-1:0] accel_y,
    input  wire logic signed [imuks_pkg::DATA_W-1:0] accel_z,
    input  wire logic signed [imuks_pkg::DATA_W-1:0] rate_x,
    input  wire logic signed [imuks_pkg::DATA_W-1:0] rate_y,
    input  wire logic signed [imuks_pkg::DATA_W-1:0] rate_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [imuks_pkg::DATA_W-1:0]      smooth_accel_x,
    output logic signed [imuks_pkg::DATA_W-1:0]      smooth_accel_y,
    output logic signed [imuks_pkg::DATA_W-1:0]      smooth_accel_z,
    output logic signed [imuks_pkg::DATA_W-1:0]      smooth_rate_x,
    output logic signed [imuks_pkg::DATA_W-1:0]      smooth_rate_y,
    output logic signed [imuks_pkg::DATA_W-1:0]      smooth_rate_z
);

    imuks_pkg::imuks_cmd_t        cmd;
    logic [imuks_pkg::DATA_W-1:0] axis_in  [imuks_pkg::AXES];
    logic [imuks_pkg::DATA_W-1:0] axis_out [imuks_pkg::AXES];
    logic [imuks_pkg::DATA_W-1:0] z_in     [imuks_pkg::CHANNELS];
    logic [imuks_pkg::DATA_W-1:0] est_out  [imuks_pkg::CHANNELS];

    // Gather the axis samples in order
    assign axis_in[0] = accel_x;
    assign axis_in[1] = accel_y;
    assign axis_in[2] = accel_z;
    assign axis_in[3] = rate_x;
    assign axis_in[4] = rate_y;
    assign axis_in[5] = rate_z;

    // Only the configured channels are filtered; the rest read as zero.
    always_comb
    begin
        for (int i = 0; i < imuks_pkg::CHANNELS; i++)
        begin
            z_in[i] = axis_in[i];
        end
        for (int i = 0; i < imuks_pkg::AXES; i++)
        begin
            axis_out[i] = '0;
        end
        for (int i = 0; i < imuks_pkg::CHANNELS; i++)
        begin
            axis_out[i] = est_out[i];
        end
    end

    assign smooth_accel_x = axis_out[0];
    assign smooth_accel_y = axis_out[1];
    assign smooth_accel_z = axis_out[2];
    assign smooth_rate_x  = axis_out[3];
    assign smooth_rate_y  = axis_out[4];
    assign smooth_rate_z  = axis_out[5];

    imuks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    imuks_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .z_in      (z_in),
        .est_out   (est_out)
    );

endmodule
`default_nettype wire

FILE: bench/imuks_smoother_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the six-axis IMU smoother that mirrors the filter state and checks each estimate.
module imuks_smoother_checker
    import imuks_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [REG_IDX_W-1:0]        cfg_addr,
    input  wire logic [NOISE_W-1:0]          cfg_wdata,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic signed [DATA_W-1:0]    accel_x,
    input  wire logic signed [DATA_W-1:0]    accel_y,
    input  wire logic signed [DATA_W-1:0]    accel_z,
    input  wire logic signed [DATA_W-1:0]    rate_x,
    input  wire logic signed [DATA_W-1:0]    rate_y,
    input  wire logic signed [DATA_W-1:0]    rate_z,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic signed [DATA_W-1:0]    smooth_accel_x,
    input  wire logic signed [DATA_W-1:0]    smooth_accel_y,
    input  wire logic signed [DATA_W-1:0]    smooth_accel_z,
    input  wire logic signed [DATA_W-1:0]    smooth_rate_x,
    input  wire logic signed [DATA_W-1:0]    smooth_rate_y,
    input  wire logic signed [DATA_W-1:0]    smooth_rate_z,
    output int                               fail_count,
    output int                               pending
);

    typedef logic [AXES-1:0][DATA_W-1:0] axis_vec_t;

    localparam logic [63:0]        UNITY     = 64'd1 << FRAC_BITS;
    localparam logic [63:0]        P_MAX     = 64'hFFFF_FFFF;
    localparam logic [NOISE_W-1:0] Q_DEFAULT = NOISE_W'((UNITY + 64'd50) / 64'd100);
    localparam logic [NOISE_W-1:0] R_DEFAULT = NOISE_W'((64'd5 * UNITY + 64'd50) / 64'd100);
    localparam longint             EST_MAX   = 64'sd2147483647;
    localparam longint             EST_MIN   = -64'sd2147483648;

    // Mirrored filter state and noise settings
    longint            est [AXES];
    logic [DATA_W-1:0] cov;
    logic              started;
    logic [NOISE_W-1:0] q_noise;
    logic [NOISE_W-1:0] r_noise;

    axis_vec_t expected_estimates [$];
    string     axis_label [AXES] = '{"smooth_accel_x", "smooth_accel_y", "smooth_accel_z",
                                     "smooth_rate_x", "smooth_rate_y", "smooth_rate_z"};

    // Runs one sample through the filter and returns the estimates it leaves behind.
    function automatic axis_vec_t filter_sample(input axis_vec_t meas);
        logic [63:0] p_pred;
        logic [63:0] denom;
        logic [63:0] gain;
        logic [63:0] omk;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        logic [63:0] p_next;
        longint      diff;
        longint      upd;
        axis_vec_t   est_out;
        if (!started)
        begin
            // The first sample is taken as the estimate; covariance is left alone.
            for (int i = 0; i < CHANNELS && i < AXES; i++)
            begin
                est[i] = longint'($signed(meas[i]));
            end
            started = 1'b1;
        end
        else
        begin
            p_pred = cov + q_noise;
            if (p_pred > P_MAX)
            begin
                p_pred = P_MAX;
            end
            denom = p_pred + r_noise;
            gain  = (denom != 64'd0) ? (p_pred << FRAC_BITS) / denom : 64'd0;
            if (gain > UNITY)
            begin
                gain = UNITY;
            end

            // Correction is floored toward minus infinity, then the sum saturates.
            for (int i = 0; i < CHANNELS && i < AXES; i++)
            begin
                diff = longint'($signed(meas[i])) - est[i];
                upd  = est[i] + (($signed(gain) * diff) >>> FRAC_BITS);
                if (upd > EST_MAX)
                begin
                    upd = EST_MAX;
                end
                else if (upd < EST_MIN)
                begin
                    upd = EST_MIN;
                end
                est[i] = upd;
            end

            // Joseph-form covariance update with truncating fixed-point steps.
            omk    = UNITY - gain;
            a      = (omk * omk) >> FRAC_BITS;
            b      = (a * p_pred) >> FRAC_BITS;
            c      = (gain * gain) >> FRAC_BITS;
            d      = (c * r_noise) >> FRAC_BITS;
            p_next = b + d;
            if (p_next > P_MAX)
            begin
                p_next = P_MAX;
            end
            cov = p_next[DATA_W-1:0];
        end

        for (int i = 0; i < AXES; i++)
        begin
            est_out[i] = (i < CHANNELS) ? est[i][DATA_W-1:0] : '0;
        end
        return est_out;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    // Watch all three ports; results are checked before new requests are queued.
    always @(posedge clk or negedge rst_n)
    begin
        axis_vec_t got;
        axis_vec_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                est[i] = 0;
            end
            cov     = DATA_W'(UNITY);
            started = 1'b0;
            q_noise = Q_DEFAULT;
            r_noise = R_DEFAULT;
            expected_estimates.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {smooth_rate_z, smooth_rate_y, smooth_rate_x,
                       smooth_accel_z, smooth_accel_y, smooth_accel_x};
                if (expected_estimates.size() == 0)
                begin
                    report_mismatch($sformatf("result with no request outstanding: %h", got));
                end
                else
                begin
                    want = expected_estimates.pop_front();
                    for (int i = 0; i < AXES; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            report_mismatch($sformatf("%s got %h, expected %h",
                                                      axis_label[i], got[i], want[i]));
                        end
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PROCESS_NOISE: q_noise = cfg_wdata;
                    REG_MEASURE_NOISE: r_noise = cfg_wdata;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                expected_estimates.push_back(filter_sample({rate_z, rate_y, rate_x,
                                                            accel_z, accel_y, accel_x}));
            end
            pending <= expected_estimates.size();
        end
    end

endmodule

FILE: bench/imu_six_axis_kalman_smoother_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the six-axis IMU smoother, with the scoreboard alongside the block.
module imu_six_axis_kalman_smoother_tb;
    import imuks_pkg::*;

    typedef logic [AXES-1:0][DATA_W-1:0] axis_vec_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SEGMENTS    = 4;
    localparam int SEG_ITEMS   = 96;
    localparam int SETTLE      = 40;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr  = REG_PROCESS_NOISE;
    logic [NOISE_W-1:0]   cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 out_ready = 1'b0;
    axis_vec_t            meas_r    = '0;

    logic                 in_ready;
    logic                 out_valid;
    logic signed [DATA_W-1:0] smooth_accel_x;
    logic signed [DATA_W-1:0] smooth_accel_y;
    logic signed [DATA_W-1:0] smooth_accel_z;
    logic signed [DATA_W-1:0] smooth_rate_x;
    logic signed [DATA_W-1:0] smooth_rate_y;
    logic signed [DATA_W-1:0] smooth_rate_z;

    int        fail_count;
    int        pending;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        cycle_count   = 0;
    int        trend [AXES]  = '{default: 0};
    axis_vec_t next_meas;

    always #1 clk = ~clk;

    imu_six_axis_kalman_smoother uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .accel_x        (meas_r[0]),
        .accel_y        (meas_r[1]),
        .accel_z        (meas_r[2]),
        .rate_x         (meas_r[3]),
        .rate_y         (meas_r[4]),
        .rate_z         (meas_r[5]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .smooth_accel_x (smooth_accel_x),
        .smooth_accel_y (smooth_accel_y),
        .smooth_accel_z (smooth_accel_z),
        .smooth_rate_x  (smooth_rate_x),
        .smooth_rate_y  (smooth_rate_y),
        .smooth_rate_z  (smooth_rate_z)
    );

    imuks_smoother_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .accel_x        (meas_r[0]),
        .accel_y        (meas_r[1]),
        .accel_z        (meas_r[2]),
        .rate_x         (meas_r[3]),
        .rate_y         (meas_r[4]),
        .rate_z         (meas_r[5]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .smooth_accel_x (smooth_accel_x),
        .smooth_accel_y (smooth_accel_y),
        .smooth_accel_z (smooth_accel_z),
        .smooth_rate_x  (smooth_rate_x),
        .smooth_rate_y  (smooth_rate_y),
        .smooth_rate_z  (smooth_rate_z),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Result side back-pressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one sample after an optional random gap and holds it until accepted.
    task automatic send_sample(input axis_vec_t meas);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        meas_r   <= meas;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every outstanding request has its result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes both noise registers while the block is idle.
    task automatic set_noise(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PROCESS_NOISE;
        cfg_wdata <= q;
        @(posedge clk);
        cfg_addr  <= REG_MEASURE_NOISE;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Noise values mix the extremes, typical sub-unity values and full-width noise.
    function automatic logic [NOISE_W-1:0] pick_noise();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return NOISE_W'($urandom_range(65535));
            3:       return NOISE_W'($urandom_range(2000));
            default: return NOISE_W'($urandom());
        endcase
    endfunction

    // Mostly a slowly drifting signal per axis, with spikes, full-range noise and rails.
    task automatic next_imu_sample(output axis_vec_t meas);
        int pick;
        for (int i = 0; i < AXES; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
            begin
                trend[i] = int'($urandom()) >>> $urandom_range(24);
                meas[i]  = trend[i];
            end
            else if (pick < 72)
            begin
                trend[i] = trend[i] + int'($urandom_range(4095)) - 2048;
                meas[i]  = trend[i] + int'($urandom_range(2047)) - 1024;
            end
            else if (pick < 90)
            begin
                meas[i] = $urandom();
            end
            else
            begin
                case ($urandom_range(3))
                    0:       meas[i] = 32'h7FFF_FFFF;
                    1:       meas[i] = 32'h8000_0000;
                    2:       meas[i] = 32'h0000_0000;
                    default: meas[i] = 32'hFFFF_FFFF;
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples, listed rate_z down to accel_x. The first one after reset
        // is copied into the estimates; the next ones swing between the rails.
        send_sample({32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF,
                     32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_sample({6{32'h8000_0000}});
        send_sample({6{32'h7FFF_FFFF}});
        send_sample({6{32'h0000_0000}});
        send_sample({6{32'hFFFF_FFFF}});
        send_sample({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});

        // No noise at all: unity gain collapses the covariance to zero, after which
        // the gain denominator is zero and the estimates must freeze.
        set_noise('0, '0);
        send_sample({6{32'h0001_0000}});
        send_sample({6{32'h7FFF_FFFF}});
        send_sample({6{32'h8000_0000}});

        // Largest process noise with no measurement noise.
        set_noise('1, '0);
        send_sample({6{32'h8000_0000}});
        send_sample({6{32'h7FFF_FFFF}});

        // Largest measurement noise with no process noise.
        set_noise('0, '1);
        send_sample({6{32'h0000_0000}});
        send_sample({6{32'h7FFF_FFFF}});
        send_sample({6{32'h8000_0000}});

        // Both noise terms at full scale.
        set_noise('1, '1);
        send_sample({6{32'h7FFF_FFFF}});
        send_sample({6{32'h8000_0000}});
        send_sample({6{32'hC000_0000}});

        // Random part in three idling profiles, each over several noise settings.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                set_noise(pick_noise(), pick_noise());
                repeat (SEG_ITEMS)
                begin
                    next_imu_sample(next_meas);
                    send_sample(next_meas);
                end
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
